@@ rtl/hwe_exact_test_pvalue_macros.svh @@
// Assertion macros for the exact Hardy-Weinberg test block.
// Used by the checker module; needs signals clk and rst_n in scope.
`ifndef HWE_EXACT_TEST_PVALUE_MACROS_SVH
`define HWE_EXACT_TEST_PVALUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HWE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hwe_pkg.sv @@
// Package for the exact Hardy-Weinberg test block: widths, defaults, status codes.
// No dependencies.
package hwe_pkg;
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int FRAC_BITS_DEF   = 48;
  localparam int CNT_W  = 13;
  localparam int SUM_W  = CNT_W + 2;
  localparam int ACC_W  = 64;
  localparam int MUL_W  = 32;
  localparam int P_W    = 33;
  localparam int ST_W   = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd2;

  localparam logic [P_W-1:0] P_ONE = {1'b1, {(P_W-1){1'b0}}};
endpackage

@@ rtl/hwe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hwe_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 4097
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/hwe_exact_test_pvalue.sv @@
// Top level of the exact Hardy-Weinberg test: sequencer, shared multiplier and divider.
// Depends on hwe_pkg and hwe_ram.
//
// One item in, one item out. The block builds the heterozygote-count probability table in
// a RAM of MAX_SAMPLES+1 entries, then sums the tail and divides by the total. Each table
// entry costs one pass through the shared 32x32 multiplier (four products) and the shared
// restoring divider (one quotient bit a cycle); the tail pass then reads the table back
// entry by entry, and a final division gives the p-value. An item with N genotypes builds
// up to N+1 entries; empty or oversized inputs skip the table and finish with a p-value of
// one. in_tready is high only while the block is idle; a finished item waits in the
// output register.
module hwe_exact_test_pvalue
  import hwe_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // het_count[12:0], hom_a_count[25:13], hom_b_count[38:26], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // p_value[32:0], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [ST_W-1:0]        out_tuser
);
  localparam int VW   = FRAC_BITS + 4;
  localparam int AW   = $clog2(MAX_SAMPLES + 1);
  localparam int PW   = ACC_W + MUL_W;
  localparam int CNTW = $clog2(PW + 1);
  localparam logic [ACC_W-1:0] ONE_FIX = ACC_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] VAL_MAX = ACC_W'({VW{1'b1}});

  localparam logic [4:0] S_IDLE = 5'd0,  S_CHK = 5'd1,   S_MIDM = 5'd2,  S_MIDD = 5'd3;
  localparam logic [4:0] S_DIV  = 5'd4,  S_MIDFIX = 5'd5, S_DNINIT = 5'd6, S_DN = 5'd7;
  localparam logic [4:0] S_DB   = 5'd8,  S_ML = 5'd9,    S_MH = 5'd10,  S_DNW = 5'd11;
  localparam logic [4:0] S_UPINIT = 5'd12, S_UPCC = 5'd13, S_UP = 5'd14, S_UB = 5'd15;
  localparam logic [4:0] S_UPW  = 5'd16, S_OBS = 5'd17,  S_OBSW = 5'd18, S_TL = 5'd19;
  localparam logic [4:0] S_TA   = 5'd20, S_PV = 5'd21,   S_PVW = 5'd22, S_FIN = 5'd23;

  localparam logic [1:0] K_MID = 2'd0, K_DN = 2'd1, K_UP = 2'd2, K_PV = 2'd3;

  logic [4:0]       state_r, state_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [CNT_W-1:0] het_r, het_nxt;
  logic [SUM_W-1:0] rare_r, rare_nxt, geno_r, geno_nxt;
  logic [SUM_W-1:0] h_r, h_nxt, mid_r, mid_nxt, cr_r, cr_nxt, cc_r, cc_nxt;
  logic [MUL_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [ACC_W-1:0] cur_v_r, cur_v_nxt, total_r, total_nxt, tail_r, tail_nxt;
  logic [ACC_W-1:0] obs_r, obs_nxt, plo_r, plo_nxt;
  logic [ACC_W:0]   rem_r, rem_nxt;
  logic [PW-1:0]    num_r, num_nxt, q_r, q_nxt;
  logic [ACC_W-1:0] d_r, d_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt;
  logic [P_W-1:0]   res_p_r, res_p_nxt, op_r, op_nxt;
  logic [ST_W-1:0]  res_st_r, res_st_nxt, ost_r, ost_nxt;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic [ACC_W:0]     r2;
  logic               qbit;
  logic [ACC_W-1:0]   sval;
  logic [ACC_W:0]     tot_sum, tail_sum;
  logic [SUM_W-1:0]   in_het, in_ha, in_hb, homc, homr;
  logic [SUM_W-1:0]   mid_q;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [VW-1:0]      wdata;
  logic [VW-1:0]      rdata;

  assign prod = mul_a * mul_b;
  assign r2   = {rem_r[ACC_W-1:0], num_r[PW-1]};
  assign qbit = (r2 >= {1'b0, d_r});
  assign sval = (q_r[PW-1:VW] != '0) ? VAL_MAX : ACC_W'(q_r[VW-1:0]);
  assign tot_sum  = {1'b0, total_r} + {1'b0, sval};
  assign tail_sum = {1'b0, tail_r} + {{(ACC_W+1-VW){1'b0}}, rdata};
  assign in_het = SUM_W'(in_tdata[12:0]);
  assign in_ha  = SUM_W'(in_tdata[25:13]);
  assign in_hb  = SUM_W'(in_tdata[38:26]);
  assign homc   = (in_ha < in_hb) ? in_hb : in_ha;
  assign homr   = (in_ha < in_hb) ? in_ha : in_hb;
  assign mid_q  = q_r[SUM_W-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_TDATA_W'(op_r);
  assign out_tuser  = ost_r;

  hwe_ram #(.WIDTH(VW), .DEPTH(MAX_SAMPLES + 1)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MIDM: begin
        mul_a = MUL_W'(rare_r);
        mul_b = MUL_W'({geno_r, 1'b0} - {1'b0, rare_r});
      end
      S_DN: begin
        mul_a = MUL_W'(h_r);
        mul_b = MUL_W'(h_r - SUM_W'(1));
      end
      S_DB: begin
        mul_a = MUL_W'(cr_r) + MUL_W'(1);
        mul_b = MUL_W'(cc_r) + MUL_W'(1);
      end
      S_UP: begin
        mul_a = MUL_W'(cr_r);
        mul_b = MUL_W'(cc_r);
      end
      S_UB: begin
        mul_a = MUL_W'(h_r) + MUL_W'(2);
        mul_b = MUL_W'(h_r) + MUL_W'(1);
      end
      S_ML: begin
        mul_a = cur_v_r[MUL_W-1:0];
        mul_b = a_r;
      end
      S_MH: begin
        mul_a = cur_v_r[ACC_W-1:MUL_W];
        mul_b = a_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    het_nxt = het_r;
    rare_nxt = rare_r;
    geno_nxt = geno_r;
    h_nxt = h_r;
    mid_nxt = mid_r;
    cr_nxt = cr_r;
    cc_nxt = cc_r;
    a_nxt = a_r;
    b_nxt = b_r;
    cur_v_nxt = cur_v_r;
    total_nxt = total_r;
    tail_nxt = tail_r;
    obs_nxt = obs_r;
    plo_nxt = plo_r;
    rem_nxt = rem_r;
    num_nxt = num_r;
    q_nxt = q_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    ov_nxt = ov_r;
    res_p_nxt = res_p_r;
    res_st_nxt = res_st_r;
    op_nxt = op_r;
    ost_nxt = ost_r;
    we = 1'b0;
    waddr = AW'(h_r);
    raddr = AW'(h_r);
    wdata = sval[VW-1:0];
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          het_nxt = in_tdata[12:0];
          rare_nxt = {homr[SUM_W-2:0], 1'b0} + in_het;
          geno_nxt = in_het + homc + homr;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        res_p_nxt = P_ONE;
        if (geno_r == '0) begin
          res_st_nxt = ST_EMPTY;
          state_nxt = S_FIN;
        end else if (32'(geno_r) > 32'(MAX_SAMPLES)) begin
          res_st_nxt = ST_OVER;
          state_nxt = S_FIN;
        end else begin
          res_st_nxt = ST_OK;
          state_nxt = S_MIDM;
        end
      end
      S_MIDM: begin
        plo_nxt = prod;
        state_nxt = S_MIDD;
      end
      S_MIDD: begin
        num_nxt = PW'(plo_r);
        d_nxt = ACC_W'({geno_r, 1'b0});
        rem_nxt = '0;
        cnt_nxt = CNTW'(PW);
        kind_nxt = K_MID;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = qbit ? (r2 - {1'b0, d_r}) : r2;
        num_nxt = {num_r[PW-2:0], 1'b0};
        q_nxt = {q_r[PW-2:0], qbit};
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          unique case (kind_r)
            K_MID: state_nxt = S_MIDFIX;
            K_DN:  state_nxt = S_DNW;
            K_UP:  state_nxt = S_UPW;
            K_PV:  state_nxt = S_PVW;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MIDFIX: begin
        h_nxt = mid_q + SUM_W'(rare_r[0] != mid_q[0]);
        mid_nxt = h_nxt;
        cr_nxt = (rare_r - h_nxt) >> 1;
        cur_v_nxt = ONE_FIX;
        total_nxt = ONE_FIX;
        we = 1'b1;
        waddr = AW'(h_nxt);
        wdata = ONE_FIX[VW-1:0];
        state_nxt = S_DNINIT;
      end
      S_DNINIT: begin
        cc_nxt = geno_r - h_r - cr_r;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (h_r > SUM_W'(1)) begin
          a_nxt = prod[MUL_W-1:0];
          state_nxt = S_DB;
        end else begin
          state_nxt = S_UPINIT;
        end
      end
      S_DB: begin
        b_nxt = {prod[MUL_W-3:0], 2'b00};
        kind_nxt = K_DN;
        state_nxt = S_ML;
      end
      S_ML: begin
        plo_nxt = prod;
        state_nxt = S_MH;
      end
      S_MH: begin
        num_nxt = {prod, {MUL_W{1'b0}}} + PW'(plo_r);
        d_nxt = ACC_W'(b_r);
        rem_nxt = '0;
        cnt_nxt = CNTW'(PW);
        state_nxt = S_DIV;
      end
      S_DNW: begin
        we = 1'b1;
        waddr = AW'(h_r - SUM_W'(2));
        total_nxt = tot_sum[ACC_W] ? '1 : tot_sum[ACC_W-1:0];
        cur_v_nxt = sval;
        h_nxt = h_r - SUM_W'(2);
        cr_nxt = cr_r + SUM_W'(1);
        cc_nxt = cc_r + SUM_W'(1);
        state_nxt = S_DN;
      end
      S_UPINIT: begin
        h_nxt = mid_r;
        cur_v_nxt = ONE_FIX;
        cr_nxt = (rare_r - mid_r) >> 1;
        state_nxt = S_UPCC;
      end
      S_UPCC: begin
        cc_nxt = geno_r - h_r - cr_r;
        state_nxt = S_UP;
      end
      S_UP: begin
        if ({1'b0, h_r} + (SUM_W+1)'(2) <= {1'b0, rare_r}) begin
          a_nxt = {prod[MUL_W-3:0], 2'b00};
          state_nxt = S_UB;
        end else begin
          state_nxt = S_OBS;
        end
      end
      S_UB: begin
        b_nxt = prod[MUL_W-1:0];
        kind_nxt = K_UP;
        state_nxt = S_ML;
      end
      S_UPW: begin
        we = 1'b1;
        waddr = AW'(h_r + SUM_W'(2));
        total_nxt = tot_sum[ACC_W] ? '1 : tot_sum[ACC_W-1:0];
        cur_v_nxt = sval;
        h_nxt = h_r + SUM_W'(2);
        cr_nxt = cr_r - SUM_W'(1);
        cc_nxt = cc_r - SUM_W'(1);
        state_nxt = S_UP;
      end
      S_OBS: begin
        raddr = AW'(het_r);
        state_nxt = S_OBSW;
      end
      S_OBSW: begin
        obs_nxt = ACC_W'(rdata);
        h_nxt = SUM_W'(rare_r[0]);
        tail_nxt = '0;
        state_nxt = S_TL;
      end
      S_TL: begin
        state_nxt = S_TA;
      end
      S_TA: begin
        if (ACC_W'(rdata) <= obs_r) begin
          tail_nxt = tail_sum[ACC_W] ? '1 : tail_sum[ACC_W-1:0];
        end
        if ({1'b0, h_r} + (SUM_W+1)'(2) <= {1'b0, rare_r}) begin
          h_nxt = h_r + SUM_W'(2);
          state_nxt = S_TL;
        end else begin
          state_nxt = S_PV;
        end
      end
      S_PV: begin
        if (tail_r >= total_r) begin
          res_p_nxt = P_ONE;
          state_nxt = S_FIN;
        end else begin
          rem_nxt = {1'b0, tail_r};
          num_nxt = '0;
          q_nxt = '0;
          d_nxt = total_r;
          cnt_nxt = CNTW'(32);
          kind_nxt = K_PV;
          state_nxt = S_DIV;
        end
      end
      S_PVW: begin
        res_p_nxt = q_r[P_W-1:0];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          op_nxt = res_p_r;
          ost_nxt = res_st_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
    kind_r <= kind_nxt;
    het_r <= het_nxt;
    rare_r <= rare_nxt;
    geno_r <= geno_nxt;
    h_r <= h_nxt;
    mid_r <= mid_nxt;
    cr_r <= cr_nxt;
    cc_r <= cc_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    cur_v_r <= cur_v_nxt;
    total_r <= total_nxt;
    tail_r <= tail_nxt;
    obs_r <= obs_nxt;
    plo_r <= plo_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
    cnt_r <= cnt_nxt;
    res_p_r <= res_p_nxt;
    res_st_r <= res_st_nxt;
    op_r <= op_nxt;
    ost_r <= ost_nxt;
  end
endmodule

@@ rtl/hwe_chk.sv @@
// Port-level checker for the exact Hardy-Weinberg test block, with its bind.
// Depends on hwe_pkg and hwe_exact_test_pvalue_macros.svh.
`include "hwe_exact_test_pvalue_macros.svh"

module hwe_chk
  import hwe_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [ST_W-1:0]        out_tuser
);
  `HWE_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `HWE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output item dropped")
  `HWE_ASSERT_NOW(a_status_p_one, out_tvalid && out_tuser != ST_OK, out_tdata[P_W-1:0] == P_ONE, "error status without p of one")
  `HWE_ASSERT_NOW(a_p_range, out_tvalid && out_tdata[P_W-1], out_tdata[P_W-2:0] == '0, "p above one")
  `HWE_ASSERT_NOW(a_status_code, out_tvalid, out_tuser == ST_OK || out_tuser == ST_EMPTY || out_tuser == ST_OVER, "bad status")
endmodule

bind hwe_exact_test_pvalue hwe_chk u_hwe_chk (.*);
